@@ hw/rtl/urb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_pkg
// Shared codes, constants and types for the UART ring buffers with XON/XOFF.
// ----------------------------------------------------------------------------
package urb_pkg;

  // item action codes
  localparam logic [1:0] ACT_LINE_RX  = 2'd0;
  localparam logic [1:0] ACT_HOST_RD  = 2'd1;
  localparam logic [1:0] ACT_HOST_WR  = 2'd2;
  localparam logic [1:0] ACT_TX_READY = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FLOW_ENABLE = 2'd0;
  localparam logic [1:0] REG_FLOW_MARK   = 2'd1;
  localparam logic [1:0] REG_INJECT_CR   = 2'd2;

  // characters
  localparam logic [7:0] CTRL_XON  = 8'h11;
  localparam logic [7:0] CTRL_XOFF = 8'h13;
  localparam logic [7:0] CTRL_NONE = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [4:0] FLOW_MARK_RESET = 5'd5;

  typedef enum logic {
    S_IDLE,
    S_LF
  } state_t;

  // where the data byte of a staged result comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RX,
    SRC_TX
  } src_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] line_byte;
    logic       line_valid;
    logic       write_accepted;
    logic       rx_overflow;
    logic [5:0] rx_fill;
    logic       rx_empty;
    logic       tx_full;
    logic       flow_paused;
  } result_t;

endpackage

@@ hw/rtl/urb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_if
// Handshake channels of the UART ring buffers: item in, result out, config.
// ----------------------------------------------------------------------------
interface urb_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface urb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [7:0] line_byte;
  logic       line_valid;
  logic       write_accepted;
  logic       rx_overflow;
  logic [5:0] rx_fill;
  logic       rx_empty;
  logic       tx_full;
  logic       flow_paused;

  modport source (output valid, read_data, read_valid, line_byte, line_valid,
                  write_accepted, rx_overflow, rx_fill, rx_empty, tx_full,
                  flow_paused, input ready);
  modport sink   (input valid, read_data, read_valid, line_byte, line_valid,
                  write_accepted, rx_overflow, rx_fill, rx_empty, tx_full,
                  flow_paused, output ready);
endinterface

interface urb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/uart_ring_buffers_xon_xoff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffers_xon_xoff
// Receive and transmit byte rings between a UART line and a host, with
// XON/XOFF flow control on receive fill and optional CR before LF.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                    | transaction
//  ---------+-----+--------------------------------------------+-------------
//  item     | in  | action, data_byte                          | valid & ready
//  result   | out | read/line bytes, flags, rx_fill, status    | valid & ready
//  cfg      | in  | index, data (flow_enable, flow_mark, inj.) | valid & ready
//
//  One item per cycle unless results stall; a host newline stored as CR+LF
//  holds item.ready low for the LF write (one transmit ring write port).
//  Ring reads use a synchronous memory read; the byte is merged into the
//  result as it moves from the staging register to the output.
//  rst is synchronous; both rings come up empty, no memory clearing pass.
//  A stalled result holds in the output register; a second staged result
//  backs up into item.ready.
// ----------------------------------------------------------------------------
module uart_ring_buffers_xon_xoff
  import urb_pkg::*;
#(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  urb_item_if.sink          item,
  urb_result_if.source      result,
  urb_cfg_if.sink           cfg
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int SW    = RX_AW + 6;

  // configuration
  logic       flow_enable;
  logic [4:0] flow_mark;
  logic       inject_cr;

  // ring state
  logic [RX_AW-1:0] rx_rp, rx_rp_next;
  logic [RX_AW-1:0] rx_wp, rx_wp_next;
  logic [RX_AW-1:0] rx_count, rx_count_next;
  logic [TX_AW-1:0] tx_rp, tx_rp_next;
  logic [TX_AW-1:0] tx_wp, tx_wp_next;
  logic [TX_AW-1:0] tx_count, tx_count_next;
  logic             flow_on, flow_on_next;
  logic [7:0]       pend, pend_next;
  state_t           state, state_next;

  // memories
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] tx_wdata;
  logic [7:0] rx_rd, tx_rd;

  // staging and output
  result_t stg, stg_d, res_q, res_d;
  src_t    stg_src, src_d;
  logic    stg_valid, stg_move, out_valid;
  logic    item_fire;

  logic [SW-1:0] fill_sum;

  assign stg_move   = stg_valid && (!out_valid || result.ready);
  assign item.ready = (state == S_IDLE) && (!stg_valid || stg_move);
  assign item_fire  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_enable <= 1'b0;
      flow_mark   <= FLOW_MARK_RESET;
      inject_cr   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FLOW_ENABLE: flow_enable <= cfg.data[0];
        REG_FLOW_MARK:   flow_mark   <= cfg.data[4:0];
        REG_INJECT_CR:   inject_cr   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // item processing: pointer/count updates, memory commands, result fields
  always_comb begin
    rx_rp_next    = rx_rp;
    rx_wp_next    = rx_wp;
    rx_count_next = rx_count;
    tx_rp_next    = tx_rp;
    tx_wp_next    = tx_wp;
    tx_count_next = tx_count;
    flow_on_next  = flow_on;
    pend_next     = pend;
    state_next    = state;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    tx_wdata      = item.data_byte;
    stg_d         = '0;
    src_d         = SRC_NONE;
    fill_sum      = '0;

    if (state == S_LF) begin
      // second half of an injected CR+LF
      tx_we      = 1'b1;
      tx_wdata   = CH_LF;
      tx_wp_next = (tx_wp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp + 1'b1;
      state_next = S_IDLE;
    end else if (item_fire) begin
      case (item.action)
        ACT_LINE_RX: begin
          if (rx_count == RX_AW'(RX_DEPTH - 1)) begin
            stg_d.rx_overflow = 1'b1;
          end else begin
            rx_we         = 1'b1;
            rx_wp_next    = (rx_wp == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp + 1'b1;
            rx_count_next = rx_count + 1'b1;
          end
          fill_sum = {6'b0, rx_count_next} + {{(RX_AW + 1){1'b0}}, flow_mark};
          if (flow_enable && flow_on && fill_sum >= SW'(RX_DEPTH)) begin
            pend_next    = CTRL_XOFF;
            flow_on_next = 1'b0;
          end
        end
        ACT_HOST_RD: begin
          if (rx_count != '0) begin
            rx_re            = 1'b1;
            src_d            = SRC_RX;
            stg_d.read_valid = 1'b1;
            rx_rp_next       = (rx_rp == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp + 1'b1;
            rx_count_next    = rx_count - 1'b1;
            if (flow_enable && !flow_on &&
                {6'b0, rx_count_next} <= {{(RX_AW + 1){1'b0}}, flow_mark}) begin
              pend_next    = CTRL_XON;
              flow_on_next = 1'b1;
            end
          end
        end
        ACT_HOST_WR: begin
          if (inject_cr && item.data_byte == CH_LF) begin
            if (tx_count <= TX_AW'(TX_DEPTH - 3)) begin
              tx_we                = 1'b1;
              tx_wdata             = CH_CR;
              tx_wp_next = (tx_wp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp + 1'b1;
              tx_count_next        = tx_count + TX_AW'(2);
              stg_d.write_accepted = 1'b1;
              state_next           = S_LF;
            end
          end else if (tx_count <= TX_AW'(TX_DEPTH - 2)) begin
            tx_we                = 1'b1;
            tx_wp_next = (tx_wp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp + 1'b1;
            tx_count_next        = tx_count + 1'b1;
            stg_d.write_accepted = 1'b1;
          end
        end
        ACT_TX_READY: begin
          if (pend != CTRL_NONE) begin
            stg_d.line_byte  = pend;
            stg_d.line_valid = 1'b1;
            pend_next        = CTRL_NONE;
          end else if (tx_count != '0) begin
            tx_re            = 1'b1;
            src_d            = SRC_TX;
            stg_d.line_valid = 1'b1;
            tx_rp_next    = (tx_rp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp + 1'b1;
            tx_count_next = tx_count - 1'b1;
          end
        end
        default: ;
      endcase
      stg_d.rx_fill     = 6'({6'b0, rx_count_next});
      stg_d.rx_empty    = (rx_count_next == '0);
      stg_d.tx_full     = (tx_count_next == TX_AW'(TX_DEPTH - 1));
      stg_d.flow_paused = !flow_on_next;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rx_rp    <= '0;
      rx_wp    <= '0;
      rx_count <= '0;
      tx_rp    <= '0;
      tx_wp    <= '0;
      tx_count <= '0;
      flow_on  <= 1'b1;
      pend     <= CTRL_NONE;
    end else begin
      state    <= state_next;
      rx_rp    <= rx_rp_next;
      rx_wp    <= rx_wp_next;
      rx_count <= rx_count_next;
      tx_rp    <= tx_rp_next;
      tx_wp    <= tx_wp_next;
      tx_count <= tx_count_next;
      flow_on  <= flow_on_next;
      pend     <= pend_next;
    end
  end

  // receive ring memory
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wp] <= item.data_byte;
    end
    if (rx_re) begin
      rx_rd <= rx_mem[rx_rp];
    end
  end

  // transmit ring memory
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wp] <= tx_wdata;
    end
    if (tx_re) begin
      tx_rd <= tx_mem[tx_rp];
    end
  end

  // staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_fire) begin
      stg_valid <= 1'b1;
    end else if (stg_move) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      stg     <= stg_d;
      stg_src <= src_d;
    end
  end

  // memory byte merged into the staged result
  always_comb begin
    res_d = stg;
    if (stg_src == SRC_RX) begin
      res_d.read_data = rx_rd;
    end
    if (stg_src == SRC_TX) begin
      res_d.line_byte = tx_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_move) begin
      res_q <= res_d;
    end
  end

  assign result.valid          = out_valid;
  assign result.read_data      = res_q.read_data;
  assign result.read_valid     = res_q.read_valid;
  assign result.line_byte      = res_q.line_byte;
  assign result.line_valid     = res_q.line_valid;
  assign result.write_accepted = res_q.write_accepted;
  assign result.rx_overflow    = res_q.rx_overflow;
  assign result.rx_fill        = res_q.rx_fill;
  assign result.rx_empty       = res_q.rx_empty;
  assign result.tx_full        = res_q.tx_full;
  assign result.flow_paused    = res_q.flow_paused;

endmodule

@@ test/uart_ring_buffers_xon_xoff_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffers_xon_xoff_tb
// Self-checking bench for the UART receive/transmit rings with XON/XOFF.
// A shadow copy of both rings, the flow state and the registers predicts the
// status of every transaction on the item channel. Results are checked in
// order as they leave the block. Stimulus is a short directed pass, then
// rounds of fill/drain phases with random data. Each round runs under its
// own register setting, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
import urb_pkg::*;

class rx_tx_ring_shadow;
  localparam int RING_DEPTH = 64;

  logic [7:0]  rx_mem [RING_DEPTH];
  logic [7:0]  tx_mem [RING_DEPTH];
  int unsigned rx_rd, rx_wr, tx_rd, tx_wr, rx_count;
  bit          flow_on;
  logic [7:0]  ctrl_byte;

  // shadow registers
  bit          flow_en;
  logic [4:0]  mark;
  bit          inject;

  result_t     due_status [$];
  int          errors;
  int          n_items, n_results, n_overflow, n_xoff, n_xon, n_refused, n_crlf;

  function new();
    reset_rings();
    errors = 0;
    n_items = 0; n_results = 0; n_overflow = 0;
    n_xoff = 0; n_xon = 0; n_refused = 0; n_crlf = 0;
  endfunction

  function void reset_rings();
    rx_rd = 0; rx_wr = 0; tx_rd = 0; tx_wr = 0; rx_count = 0;
    flow_on = 1'b1;
    ctrl_byte = CTRL_NONE;
    flow_en = 1'b0;
    mark = FLOW_MARK_RESET;
    inject = 1'b0;
  endfunction

  function int unsigned tx_used();
    return (tx_wr + RING_DEPTH - tx_rd) % RING_DEPTH;
  endfunction

  function void tx_push(logic [7:0] b);
    tx_mem[tx_wr] = b;
    tx_wr = (tx_wr + 1) % RING_DEPTH;
  endfunction

  // register write; bits above a register's width and unknown indexes drop
  function void write_reg(logic [1:0] idx, logic [7:0] d);
    case (idx)
      REG_FLOW_ENABLE: flow_en = d[0];
      REG_FLOW_MARK:   mark = d[4:0];
      REG_INJECT_CR:   inject = d[0];
      default: ;
    endcase
  endfunction

  // advance the rings by one transaction and queue the status it yields
  function void advance_rings(logic [1:0] act, logic [7:0] d);
    result_t     r;
    int unsigned free_slots;
    r = '0;
    n_items++;
    case (act)
      ACT_LINE_RX: begin
        if (rx_count >= RING_DEPTH - 1) begin
          r.rx_overflow = 1'b1;
          n_overflow++;
        end else begin
          rx_mem[rx_wr] = d;
          rx_wr = (rx_wr + 1) % RING_DEPTH;
          rx_count++;
        end
        // XOFF check runs even when the byte was dropped
        if (flow_en && flow_on && (rx_count + mark >= RING_DEPTH)) begin
          ctrl_byte = CTRL_XOFF;
          flow_on = 1'b0;
        end
      end
      ACT_HOST_RD: begin
        if (rx_count != 0) begin
          r.read_data = rx_mem[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = (rx_rd + 1) % RING_DEPTH;
          rx_count--;
          if (flow_en && !flow_on && rx_count <= mark) begin
            ctrl_byte = CTRL_XON;
            flow_on = 1'b1;
          end
        end
      end
      ACT_HOST_WR: begin
        free_slots = (RING_DEPTH - 1) - tx_used();
        if (inject && d == CH_LF) begin
          if (free_slots >= 2) begin
            tx_push(CH_CR);
            tx_push(CH_LF);
            r.write_accepted = 1'b1;
            n_crlf++;
          end
        end else if (free_slots >= 1) begin
          tx_push(d);
          r.write_accepted = 1'b1;
        end
        if (!r.write_accepted) n_refused++;
      end
      default: begin
        // pending control byte goes out ahead of ring data
        if (ctrl_byte != CTRL_NONE) begin
          r.line_byte = ctrl_byte;
          r.line_valid = 1'b1;
          if (ctrl_byte == CTRL_XOFF) n_xoff++;
          else n_xon++;
          ctrl_byte = CTRL_NONE;
        end else if (tx_used() != 0) begin
          r.line_byte = tx_mem[tx_rd];
          r.line_valid = 1'b1;
          tx_rd = (tx_rd + 1) % RING_DEPTH;
        end
      end
    endcase
    r.rx_fill = 6'(rx_count);
    r.rx_empty = (rx_count == 0);
    r.tx_full = (tx_used() == RING_DEPTH - 1);
    r.flow_paused = !flow_on;
    due_status.push_back(r);
  endfunction

  function bit check_field(string nm, int unsigned e, int unsigned g);
    if (e != g) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, e, g);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void compare_result(result_t got);
    result_t e;
    bit      bad;
    n_results++;
    if (due_status.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
      errors++;
      return;
    end
    e = due_status.pop_front();
    bad = 1'b0;
    bad |= check_field("read_data", e.read_data, got.read_data);
    bad |= check_field("read_valid", e.read_valid, got.read_valid);
    bad |= check_field("line_byte", e.line_byte, got.line_byte);
    bad |= check_field("line_valid", e.line_valid, got.line_valid);
    bad |= check_field("write_accepted", e.write_accepted, got.write_accepted);
    bad |= check_field("rx_overflow", e.rx_overflow, got.rx_overflow);
    bad |= check_field("rx_fill", e.rx_fill, got.rx_fill);
    bad |= check_field("rx_empty", e.rx_empty, got.rx_empty);
    bad |= check_field("tx_full", e.tx_full, got.tx_full);
    bad |= check_field("flow_paused", e.flow_paused, got.flow_paused);
    if (bad) errors++;
  endfunction
endclass

module uart_ring_buffers_xon_xoff_tb;
  import urb_pkg::*;

  localparam logic [1:0] REG_SPARE  = 2'd3;  // no register behind this index
  localparam int         IDLE_LIMIT = 4000;
  localparam int         HOLD_LEN   = 300;

  typedef enum int {
    MIX_FILL_RX,
    MIX_DRAIN_RX,
    MIX_FILL_TX,
    MIX_DRAIN_TX,
    MIX_EVEN
  } mix_t;

  logic clk;
  logic rst;

  urb_item_if   item_ch ();
  urb_result_if res_ch ();
  urb_cfg_if    cfg_ch ();

  uart_ring_buffers_xon_xoff i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  rx_tx_ring_shadow sb = new();

  bit quiet;            // no gaps or stalls while set
  int hold_reqs;        // long receiver hold-offs requested so far
  int idle_cycles = 0;

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_action(mix_t mix);
    logic [1:0] dom;
    case (mix)
      MIX_FILL_RX:  dom = ACT_LINE_RX;
      MIX_DRAIN_RX: dom = ACT_HOST_RD;
      MIX_FILL_TX:  dom = ACT_HOST_WR;
      MIX_DRAIN_TX: dom = ACT_TX_READY;
      default:      return 2'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 9) < 8) return dom;
    return 2'($urandom_range(0, 3));
  endfunction

  // newlines and control characters show up often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_LF;
    if (r < 30) return CH_CR;
    if (r < 35) return ($urandom_range(0, 1) != 0) ? CTRL_XON : CTRL_XOFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // drive one item transaction, then an optional gap
  task automatic send_item(logic [1:0] act, logic [7:0] d);
    int gap;
    item_ch.valid = 1'b1;
    item_ch.action = act;
    item_ch.data_byte = d;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.advance_rings(act, d);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // called at a falling edge with the item channel quiet
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (sb.due_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // result side: random stalls plus the requested long hold-off
  initial begin
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        stall_left = HOLD_LEN;
        hold_seen = hold_reqs;
      end
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
        res_ch.ready = (stall_left == 0);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        sb.compare_result({res_ch.read_data, res_ch.read_valid, res_ch.line_byte,
                           res_ch.line_valid, res_ch.write_accepted,
                           res_ch.rx_overflow, res_ch.rx_fill, res_ch.rx_empty,
                           res_ch.tx_full, res_ch.flow_paused});
      end
      if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    mix_t       mix;
    int         len;
    logic [4:0] mk;
    quiet = 1'b0;
    hold_reqs = 0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.action = ACT_LINE_RX;
    item_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FLOW_ENABLE;
    cfg_ch.data = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty read, idle transmitter, byte extremes, plain newline
    send_item(ACT_HOST_RD, 8'hFF);
    send_item(ACT_TX_READY, 8'hFF);
    send_item(ACT_LINE_RX, 8'h00);
    send_item(ACT_LINE_RX, 8'hFF);
    send_item(ACT_HOST_RD, 8'h00);
    send_item(ACT_HOST_RD, 8'h00);
    send_item(ACT_HOST_RD, 8'h00);
    send_item(ACT_HOST_WR, 8'h00);
    send_item(ACT_HOST_WR, 8'hFF);
    send_item(ACT_HOST_WR, CH_LF);
    repeat (4) send_item(ACT_TX_READY, 8'h00);
    wait_drained();

    // CR injection on, upper register bits set, spare index written
    write_reg(REG_INJECT_CR, 8'hFF);
    write_reg(REG_FLOW_MARK, 8'hE1);
    write_reg(REG_SPARE, 8'hA5);
    write_reg(REG_FLOW_ENABLE, 8'hFE);
    send_item(ACT_HOST_WR, CH_LF);
    send_item(ACT_HOST_WR, CH_CR);
    repeat (4) send_item(ACT_TX_READY, 8'h55);
    send_item(ACT_LINE_RX, 8'hAA);
    send_item(ACT_HOST_RD, 8'h00);
    wait_drained();

    // random rounds: fill/drain phases under one register setting each
    for (int rnd = 0; rnd < 4; rnd++) begin
      case (rnd)
        0:       mk = 5'd31;
        1:       mk = 5'd1;
        2:       mk = 5'd0;
        default: mk = 5'($urandom_range(1, 31));
      endcase
      write_reg(REG_FLOW_ENABLE, {7'($urandom_range(0, 127)), (rnd != 2)});
      write_reg(REG_FLOW_MARK, {3'($urandom_range(0, 7)), mk});
      write_reg(REG_INJECT_CR, {7'($urandom_range(0, 127)), (rnd % 2 == 0)});
      for (int ph = 0; ph < 5; ph++) begin
        mix = mix_t'(ph);
        len = (mix == MIX_FILL_RX || mix == MIX_FILL_TX) ? 80 : 50;
        quiet = ((rnd + ph) % 4 == 3);
        // long receiver hold-off while items keep coming
        if (mix == MIX_FILL_RX && rnd % 2 == 0) hold_reqs++;
        for (int n = 0; n < len; n++) begin
          send_item(pick_action(mix), pick_byte());
        end
        // sender pauses until every result is back
        wait_drained();
      end
    end
    quiet = 1'b0;
    wait_drained();

    $display("Covered %0d items and %0d results: %0d rx overflows, %0d XOFF, %0d XON,",
             sb.n_items, sb.n_results, sb.n_overflow, sb.n_xoff, sb.n_xon);
    $display("%0d refused host writes and %0d CR+LF pairs over four register settings.",
             sb.n_refused, sb.n_crlf);
    if (sb.due_status.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.due_status.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/urb_pkg.sv
hw/rtl/urb_if.sv
hw/rtl/uart_ring_buffers_xon_xoff.sv
test/uart_ring_buffers_xon_xoff_tb.sv
